// ----- rtl/rlge_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlge_pkg
// shared constants, register indexes and lane control type for the
// lowpass rms gain estimator
// ----------------------------------------------------------------------------
package rlge_pkg;

    localparam int DEF_BLOCK_LEN = 128;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int LEVEL_W   = 15;
    localparam int GAIN_W    = 32;
    localparam int ROOT_W    = 16;
    localparam int RAD_W     = 2 * ROOT_W;

    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_COEF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COEF    = 2'd1;

    localparam logic [CFG_W-1:0] FEEDBACK_COEF_RST = 15'd28918;
    localparam logic [CFG_W-1:0] INPUT_COEF_RST    = 15'd4096;

    localparam logic signed [32:0] ROUND_HALF = 33'sd16384;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 15'h7FFF;
    localparam logic [GAIN_W-1:0]  GAIN_MAX   = 32'h7FFF_FFFF;
    localparam logic [GAIN_W-1:0]  GAIN_NUM   = 32'h8000_0000;

    typedef struct packed {
        logic load;   // capture a new sample
        logic mul;    // register both filter products
        logic flt;    // round, saturate, update filter state
        logic sqr;    // square the filter output
        logic acc;    // add square to running sum
        logic start;  // begin mean and root, clear block state
    } lane_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/rlge_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlge_lane
// one channel: lowpass filter, square accumulation, then mean by
// bit-serial division and floor root by digit-by-digit square root
// ----------------------------------------------------------------------------
module rlge_lane
    import rlge_pkg::*;
#(
    parameter int BLOCK_LEN = DEF_BLOCK_LEN,
    localparam int CNT_W  = $clog2(BLOCK_LEN + 1),
    localparam int SUM_W  = 31 + $clog2(BLOCK_LEN),
    localparam int STEP_W = $clog2(SUM_W + 1)
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire lane_ctrl_t                 ctrl,
    input  wire logic [CFG_W-1:0]           feedback_coef,
    input  wire logic [CFG_W-1:0]           input_coef,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic [CNT_W-1:0]           count,
    output logic [LEVEL_W-1:0]              level,
    output logic                            done
);

    typedef enum logic [1:0] {P_IDLE, P_DIV, P_ROOT, P_FIN} phase_t;

    phase_t                      phase_reg;
    logic [STEP_W-1:0]           step_reg;
    logic signed [SAMPLE_W-1:0]  x_reg;
    logic signed [SAMPLE_W-1:0]  y_reg;
    logic signed [31:0]          fb_prod_reg;
    logic signed [31:0]          in_prod_reg;
    logic [30:0]                 sq_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [SUM_W-1:0]            quo_reg;
    logic [CNT_W-1:0]            rem_reg;
    logic [CNT_W-1:0]            divisor_reg;
    logic [ROOT_W-1:0]           root_reg;
    logic [ROOT_W+3:0]           srem_reg;
    logic [LEVEL_W-1:0]          level_reg;
    logic                        done_reg;

    logic signed [31:0]          fb_prod;
    logic signed [31:0]          in_prod;
    logic signed [32:0]          flt_acc;
    logic signed [SAMPLE_W-1:0]  y_next;
    logic signed [31:0]          sq_full;
    logic [CNT_W:0]              rem_sh;
    logic [CNT_W:0]              rem_diff;
    logic [ROOT_W+3:0]           srem_sh;
    logic [ROOT_W+3:0]           trial;

    always_comb
    begin
        fb_prod = $signed({1'b0, feedback_coef}) * y_reg;
        in_prod = $signed({1'b0, input_coef}) * x_reg;
        flt_acc = 33'(fb_prod_reg) + 33'(in_prod_reg) + ROUND_HALF;
        // round half up, shift by 15, then saturate when the top bits disagree
        if (flt_acc[32:30] == 3'b000 || flt_acc[32:30] == 3'b111)
        begin
            y_next = flt_acc[30:15];
        end
        else if (flt_acc[32])
        begin
            y_next = 16'sh8000;
        end
        else
        begin
            y_next = 16'sh7FFF;
        end
        sq_full  = y_reg * y_reg;
        rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
        rem_diff = rem_sh - {1'b0, divisor_reg};
        srem_sh  = {srem_reg[ROOT_W+1:0], quo_reg[RAD_W-1:RAD_W-2]};
        trial    = {2'b00, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            step_reg  <= '0;
            y_reg     <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.flt)
            begin
                y_reg <= y_next;
            end
            if (ctrl.acc)
            begin
                sum_reg <= sum_reg + SUM_W'(sq_reg);
            end
            if (ctrl.start)
            begin
                y_reg     <= '0;
                sum_reg   <= '0;
                step_reg  <= STEP_W'(SUM_W);
                phase_reg <= P_DIV;
            end
            else
            begin
                unique case (phase_reg)
                    P_IDLE:
                    begin
                    end
                    P_DIV:
                    begin
                        step_reg <= step_reg - 1'b1;
                        if (step_reg == STEP_W'(1))
                        begin
                            step_reg  <= STEP_W'(ROOT_W);
                            phase_reg <= P_ROOT;
                        end
                    end
                    P_ROOT:
                    begin
                        step_reg <= step_reg - 1'b1;
                        if (step_reg == STEP_W'(1))
                        begin
                            phase_reg <= P_FIN;
                        end
                    end
                    P_FIN:
                    begin
                        done_reg  <= 1'b1;
                        phase_reg <= P_IDLE;
                    end
                    default:
                    begin
                        phase_reg <= P_IDLE;
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg <= sample;
        end
        if (ctrl.mul)
        begin
            fb_prod_reg <= fb_prod;
            in_prod_reg <= in_prod;
        end
        if (ctrl.sqr)
        begin
            sq_reg <= sq_full[30:0];
        end
        if (ctrl.start)
        begin
            quo_reg     <= sum_reg;
            divisor_reg <= count;
            rem_reg     <= '0;
            root_reg    <= '0;
            srem_reg    <= '0;
        end
        else if (phase_reg == P_DIV)
        begin
            if (!rem_diff[CNT_W])
            begin
                rem_reg <= rem_diff[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        else if (phase_reg == P_ROOT)
        begin
            // mean fits the low radicand bits, two of them per step
            quo_reg <= {quo_reg[SUM_W-3:0], 2'b00};
            if (srem_sh >= trial)
            begin
                srem_reg <= srem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (phase_reg == P_FIN)
        begin
            level_reg <= root_reg[ROOT_W-1] ? LEVEL_MAX : root_reg[LEVEL_W-1:0];
        end
    end

    assign level = level_reg;
    assign done  = done_reg;

endmodule
`default_nettype wire

// ----- rtl/rlge_merge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlge_merge
// combines both lane levels into the saturated signed q1.31 reciprocal gain
// ----------------------------------------------------------------------------
module rlge_merge
    import rlge_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [LEVEL_W-1:0] ref_level,
    input  wire logic [LEVEL_W-1:0] mic_level,
    output logic [GAIN_W-1:0]       gain,
    output logic                    zero_difference,
    output logic                    done
);

    localparam int STEP_W = $clog2(GAIN_W + 1);

    typedef enum logic [1:0] {M_IDLE, M_DIV, M_FIN} mstate_t;

    mstate_t            state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               neg_reg;
    logic               zero_reg;
    logic [LEVEL_W-1:0] d_reg;
    logic [LEVEL_W-1:0] rem_reg;
    logic [GAIN_W-1:0]  quo_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic               flag_reg;
    logic               done_reg;

    logic signed [LEVEL_W:0] diff;
    logic [LEVEL_W:0]        diff_abs;
    logic [LEVEL_W:0]        rem_sh;
    logic [LEVEL_W:0]        rem_diff;

    always_comb
    begin
        diff     = $signed({1'b0, ref_level}) - $signed({1'b0, mic_level});
        diff_abs = diff[LEVEL_W] ? -diff : diff;
        rem_sh   = {rem_reg, quo_reg[GAIN_W-1]};
        rem_diff = rem_sh - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        step_reg  <= STEP_W'(GAIN_W);
                        state_reg <= (diff == '0) ? M_FIN : M_DIV;
                    end
                end
                M_DIV:
                begin
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == STEP_W'(1))
                    begin
                        state_reg <= M_FIN;
                    end
                end
                M_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && start)
        begin
            neg_reg  <= diff[LEVEL_W];
            zero_reg <= (diff == '0);
            d_reg    <= diff_abs[LEVEL_W-1:0];
            rem_reg  <= '0;
            quo_reg  <= GAIN_NUM;
        end
        else if (state_reg == M_DIV)
        begin
            if (!rem_diff[LEVEL_W])
            begin
                rem_reg <= rem_diff[LEVEL_W-1:0];
                quo_reg <= {quo_reg[GAIN_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[LEVEL_W-1:0];
                quo_reg <= {quo_reg[GAIN_W-2:0], 1'b0};
            end
        end
        if (state_reg == M_FIN)
        begin
            flag_reg <= zero_reg;
            if (zero_reg)
            begin
                gain_reg <= GAIN_MAX;
            end
            else if (neg_reg)
            begin
                gain_reg <= -quo_reg;
            end
            else
            begin
                // a difference of one gives 2^31, which does not fit
                gain_reg <= quo_reg[GAIN_W-1] ? GAIN_MAX : quo_reg;
            end
        end
    end

    assign gain            = gain_reg;
    assign zero_difference = flag_reg;
    assign done            = done_reg;

endmodule
`default_nettype wire

// ----- rtl/lowpass_rms_gain_estimator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lowpass_rms_gain_estimator_unit
// two-lane lowpass rms estimator with reciprocal level-difference gain
// ----------------------------------------------------------------------------
// an ordinary sample steps through mul, flt, sqr and acc before the next request
// the block's last sample adds a serial mean division over SUM_W quotient bits
// (SUM_W = 31 + clog2(BLOCK_LEN), 38 by default), a 16-step root, a 32-step gain
// division (skipped on equal levels), then m_axis_tvalid and the next request
// input is held off while a finished result waits for a busy output register
// reset clears the block state and loads the default coefficients
// ----------------------------------------------------------------------------
module lowpass_rms_gain_estimator_unit
    import rlge_pkg::*;
#(
    parameter int BLOCK_LEN = DEF_BLOCK_LEN
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [31:0]          s_axis_tdata,   // mic_sample, ref_sample
    input  wire logic                 s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [63:0]               m_axis_tdata,   // ref_level, mic_level, gain
    output logic                      m_axis_tuser    // zero_difference
);

    localparam int CNT_W = $clog2(BLOCK_LEN + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_FLT, S_SQR, S_ACC, S_START, S_LVL, S_GAIN
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              end_reg;
    logic [CFG_W-1:0]  fb_coef_reg;
    logic [CFG_W-1:0]  in_coef_reg;
    logic              out_valid_reg;
    logic [63:0]       out_data_reg;
    logic              out_user_reg;
    logic              out_pending_reg;

    lane_ctrl_t        ctrl;
    logic              accept;
    logic              mic_done;
    logic              ref_done;
    logic [LEVEL_W-1:0] mic_level;
    logic [LEVEL_W-1:0] ref_level;
    logic              merge_start;
    logic              merge_done;
    logic [GAIN_W-1:0] gain;
    logic              zero_difference;
    logic              out_free;

    assign s_axis_tready = (state_reg == S_IDLE) && !out_pending_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign merge_start   = (state_reg == S_LVL) && mic_done && ref_done;

    always_comb
    begin
        ctrl       = '0;
        ctrl.load  = accept;
        ctrl.mul   = (state_reg == S_MUL);
        ctrl.flt   = (state_reg == S_FLT);
        ctrl.sqr   = (state_reg == S_SQR);
        ctrl.acc   = (state_reg == S_ACC);
        ctrl.start = (state_reg == S_START);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_coef_reg <= FEEDBACK_COEF_RST;
            in_coef_reg <= INPUT_COEF_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_FEEDBACK_COEF)
            begin
                fb_coef_reg <= cfg_data;
            end
            else if (cfg_index == REG_INPUT_COEF)
            begin
                in_coef_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            end_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_pending_reg <= 1'b0;
        end
        else
        begin
            // finished result waits here until the output register frees up
            if (out_pending_reg && out_free)
            begin
                out_valid_reg   <= 1'b1;
                out_pending_reg <= 1'b0;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= count_reg + 1'b1;
                        end_reg   <= s_axis_tlast ||
                                     (count_reg == CNT_W'(BLOCK_LEN - 1));
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:   state_reg <= S_FLT;
                S_FLT:   state_reg <= S_SQR;
                S_SQR:   state_reg <= S_ACC;
                S_ACC:   state_reg <= end_reg ? S_START : S_IDLE;
                S_START:
                begin
                    count_reg <= '0;
                    state_reg <= S_LVL;
                end
                S_LVL:
                begin
                    if (merge_start)
                    begin
                        state_reg <= S_GAIN;
                    end
                end
                S_GAIN:
                begin
                    if (merge_done)
                    begin
                        out_pending_reg <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // lane and merge results hold still while the request input is blocked
    always_ff @(posedge clk)
    begin
        if (out_pending_reg && out_free)
        begin
            out_data_reg <= {2'b00, gain, mic_level, ref_level};
            out_user_reg <= zero_difference;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    rlge_lane #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_mic_lane (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .feedback_coef (fb_coef_reg),
        .input_coef    (in_coef_reg),
        .sample        (s_axis_tdata[15:0]),
        .count         (count_reg),
        .level         (mic_level),
        .done          (mic_done)
    );

    rlge_lane #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_ref_lane (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .feedback_coef (fb_coef_reg),
        .input_coef    (in_coef_reg),
        .sample        (s_axis_tdata[31:16]),
        .count         (count_reg),
        .level         (ref_level),
        .done          (ref_done)
    );

    rlge_merge u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (merge_start),
        .ref_level       (ref_level),
        .mic_level       (mic_level),
        .gain            (gain),
        .zero_difference (zero_difference),
        .done            (merge_done)
    );

endmodule
`default_nettype wire
